/* hdl/okt_pkg.sv */
// ----------------------------------------------------------------------------
// okt_pkg
// Shared operation codes, field widths and the result item type of the
// ordered key table.
// ----------------------------------------------------------------------------
package okt_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned KEY_W   = 16;
    localparam int unsigned MOD_W   = 8;
    localparam int unsigned ENTRY_W = KEY_W + MOD_W;
    localparam int unsigned MIDX_W  = 4;
    localparam int unsigned MCNT_W  = 5;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic              success;
        logic              was_present;
        logic [MIDX_W-1:0] match_index;
        logic [MCNT_W-1:0] entry_count;
    } t_result;

endpackage

/* hdl/ordered_key_table_insert_remove_find.sv */
// ----------------------------------------------------------------------------
// ordered_key_table_insert_remove_find
// Ordered table of key code plus modifier mask entries with find, add and
// compacting remove.
// ----------------------------------------------------------------------------
// Entries live in one single-port memory with a registered read, and one item
// is worked at a time. A search reads and then compares each entry in turn,
// stopping at the first match or after the last entry held. A remove that
// finds its entry then reads each entry behind the match and writes it one
// place down. An output register holds the finished result, so the next
// item is taken while it waits. There is no clearing pass: only entries
// below the fill count are read.
// ----------------------------------------------------------------------------
module ordered_key_table_insert_remove_find #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_key_code,
    input  logic [7:0]  i_modifier_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_success,
    output logic        o_was_present,
    output logic [3:0]  o_match_index,
    output logic [4:0]  o_entry_count
);
    import okt_pkg::*;

    logic    w_res_valid;
    logic    w_res_stall;
    t_result w_res;
    t_result w_out;

    okt_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_entry     ({i_key_code, i_modifier_mask}),
        .o_res_valid (w_res_valid),
        .i_res_stall (w_res_stall),
        .o_res       (w_res)
    );

    okt_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_stall (w_res_stall),
        .i_res       (w_res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_out)
    );

    assign o_success     = w_out.success;
    assign o_was_present = w_out.was_present;
    assign o_match_index = w_out.match_index;
    assign o_entry_count = w_out.entry_count;

endmodule

/* hdl/okt_engine.sv */
// ----------------------------------------------------------------------------
// okt_engine
// Sequencer around the entry memory: linear search, append on add, and a
// read-then-write shift loop that closes the gap left by a remove.
// ----------------------------------------------------------------------------
module okt_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [okt_pkg::OP_W-1:0]     i_operation,
    input  logic [okt_pkg::ENTRY_W-1:0]  i_entry,
    output logic                         o_res_valid,
    input  logic                         i_res_stall,
    output okt_pkg::t_result             o_res
);
    import okt_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_DISP, S_SHRD, S_SHWR, S_OUT
    } t_state;

    t_state             r_state;
    logic [OP_W-1:0]    r_op;
    logic [ENTRY_W-1:0] r_key;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_pos;
    logic               r_found;
    logic               r_success;

    logic [ENTRY_W-1:0] r_mem [CAPACITY];
    logic [ENTRY_W-1:0] r_rdata;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re;
    logic [CW-1:0]      w_raddr;
    logic [CW-1:0]      w_ptr_inc;
    logic [CW+MIDX_W-1:0] w_pos_ext;
    logic [CW+MCNT_W-1:0] w_cnt_ext;

    assign w_ptr_inc = r_ptr + ONE_C;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[IW-1:0];
        w_wdata = r_key;
        w_re    = 1'b0;
        w_raddr = r_ptr;
        case (r_state)
            S_RD: begin
                w_re = 1'b1;
            end
            S_DISP: begin
                w_we = (r_op == OP_ADD) && !r_found && (r_cnt < CAP_C);
            end
            S_SHRD: begin
                w_re    = w_ptr_inc < r_cnt;
                w_raddr = w_ptr_inc;
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[IW-1:0];
                w_wdata = r_rdata;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // single port entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_pos     <= '0;
            r_found   <= 1'b0;
            r_success <= 1'b0;
            r_op      <= OP_FIND;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_key   <= i_entry;
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        if (r_cnt == '0 || !(i_operation == OP_FIND ||
                            i_operation == OP_ADD || i_operation == OP_REMOVE)) begin
                            r_state <= S_DISP;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rdata == r_key) begin
                        r_found <= 1'b1;
                        r_state <= S_DISP;
                    end else if (w_ptr_inc == r_cnt) begin
                        r_state <= S_DISP;
                    end else begin
                        r_ptr   <= w_ptr_inc;
                        r_state <= S_RD;
                    end
                end
                S_DISP: begin
                    r_pos <= r_found ? r_ptr : '0;
                    case (r_op)
                        OP_FIND: begin
                            r_success <= r_found;
                            r_state   <= S_OUT;
                        end
                        OP_ADD: begin
                            r_state <= S_OUT;
                            if (r_found) begin
                                r_success <= 1'b1;
                            end else if (r_cnt < CAP_C) begin
                                r_success <= 1'b1;
                                r_cnt     <= r_cnt + ONE_C;
                            end else begin
                                r_success <= 1'b0;
                            end
                        end
                        OP_REMOVE: begin
                            r_success <= r_found;
                            if (r_found) begin
                                r_state <= S_SHRD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: begin
                            r_success <= 1'b0;
                            r_state   <= S_OUT;
                        end
                    endcase
                end
                S_SHRD: begin
                    if (w_ptr_inc < r_cnt) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_cnt   <= r_cnt - ONE_C;
                        r_state <= S_OUT;
                    end
                end
                S_SHWR: begin
                    r_ptr   <= w_ptr_inc;
                    r_state <= S_SHRD;
                end
                S_OUT: begin
                    if (!i_res_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_pos_ext = (CW + MIDX_W)'(r_pos);
    assign w_cnt_ext = (CW + MCNT_W)'(r_cnt);

    assign o_in_stall              = (r_state != S_IDLE);
    assign o_res_valid             = (r_state == S_OUT);
    assign o_res.success           = r_success;
    assign o_res.was_present       = r_found;
    assign o_res.match_index       = w_pos_ext[MIDX_W-1:0];
    assign o_res.entry_count       = w_cnt_ext[MCNT_W-1:0];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_cnt != $past(r_cnt)) |->
            (r_cnt == $past(r_cnt) + ONE_C) || (r_cnt == $past(r_cnt) - ONE_C))
        else $error("entry count moved by more than one");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP) |-> !w_we)
        else $error("memory written during search");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |-> (w_ptr_inc < r_cnt) && r_found && (r_op == OP_REMOVE))
        else $error("shift write outside held entries");

    a_fail_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.was_present |-> (o_res.match_index == '0))
        else $error("index reported without a match");
`endif

endmodule

/* hdl/okt_out_stage.sv */
// ----------------------------------------------------------------------------
// okt_out_stage
// Output register for result items; frees the engine as soon as a result
// is parked here.
// ----------------------------------------------------------------------------
module okt_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_stall,
    input  okt_pkg::t_result  i_res,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output okt_pkg::t_result  o_res
);
    import okt_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    w_load;

    assign o_res_stall = r_valid && i_out_stall;
    assign w_load      = i_res_valid && !o_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
